// ----- hw/rtl/wsfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   typedef enum logic [5:0] {
      PH_HDR0 = 6'b000001,
      PH_HDR1 = 6'b000010,
      PH_EXT  = 6'b000100,
      PH_MASK = 6'b001000,
      PH_DATA = 6'b010000,
      PH_SKIP = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic       truncated;
   } step_result_type;

   localparam logic [7:0] FIN_BIT        = 8'h80;
   localparam logic [7:0] OPCODE_FIELD   = 8'h0F;
   localparam logic [7:0] OPCODE_TEXT    = 8'h01;
   localparam logic [7:0] MASK_BIT       = 8'h80;
   localparam logic [7:0] LEN7_FIELD     = 8'h7F;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [6:0] LEN_EXT64      = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

endpackage
`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side frame deframer: final text frames only, unmasks payload bytes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            fields
//  req_     in   req_valid/req_ready  rx_byte[7:0], chunk_end
//  rsp_     out  rsp_valid/rsp_ready  payload_byte[7:0], payload_last, truncated
//
//  One word per cycle sustained while rsp_ready holds; each word passes the
//  input register, then the parse step into the result register.
//  The input register steps whenever the result register is empty or drained
//  in the same cycle, so a stalled result holds at most one word behind it.
//  Synchronous reset returns the parser to the first header byte and empties
//  both registers.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_chunk_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_payload_last,
   output logic            rsp_truncated
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_trunc_ff;
   logic       step;
   wsfd_pkg::step_result_type result;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   wsfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .rx_byte   (in_byte_ff),
      .chunk_end (in_end_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_chunk_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= result.emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (step && result.emit) begin
         out_byte_ff  <= result.payload_byte;
         out_last_ff  <= result.payload_last;
         out_trunc_ff <= result.truncated;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_payload_last = out_last_ff;
   assign rsp_truncated    = out_trunc_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/wsfd_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parse
// Frame header, length and mask key tracking; one byte per step, unmask.
// ----------------------------------------------------------------------------
module wsfd_parse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_en,
   input  wire logic [7:0]                rx_byte,
   input  wire logic                      chunk_end,
   output wsfd_pkg::step_result_type      result
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          ext_left_ff, ext_left_in;
   logic [63:0]         length_ff, length_in;
   logic [63:0]         count_ff, count_in;
   logic [31:0]         key_ff, key_in;
   logic [2:0]          key_left_ff, key_left_in;
   logic                masked_ff, masked_in;

   logic [6:0]  len7;
   logic [7:0]  key_byte;
   logic [63:0] count_inc;
   wsfd_pkg::phase_type after_len;

   always_comb begin
      len7      = 7'(rx_byte & wsfd_pkg::LEN7_FIELD);
      count_inc = count_ff + 64'd1;
      case (count_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!masked_ff) begin
         key_byte = 8'h00;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      ext_left_in = ext_left_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      masked_in   = masked_ff;
      result      = '0;
      after_len   = wsfd_pkg::PH_SKIP;

      case (phase_ff)
         wsfd_pkg::PH_HDR0: begin
            if ((rx_byte & wsfd_pkg::FIN_BIT) != 8'h00 &&
                (rx_byte & wsfd_pkg::OPCODE_FIELD) == wsfd_pkg::OPCODE_TEXT) begin
               phase_in = wsfd_pkg::PH_HDR1;
            end else begin
               phase_in = wsfd_pkg::PH_SKIP;
            end
         end
         wsfd_pkg::PH_HDR1: begin
            masked_in = (rx_byte & wsfd_pkg::MASK_BIT) != 8'h00;
            if (len7 == wsfd_pkg::LEN_EXT16) begin
               length_in   = 64'd0;
               ext_left_in = wsfd_pkg::EXT16_BYTES;
               phase_in    = wsfd_pkg::PH_EXT;
            end else if (len7 == wsfd_pkg::LEN_EXT64) begin
               length_in   = 64'd0;
               ext_left_in = wsfd_pkg::EXT64_BYTES;
               phase_in    = wsfd_pkg::PH_EXT;
            end else begin
               length_in = 64'(len7);
               if (masked_in) begin
                  key_left_in = wsfd_pkg::MASK_KEY_BYTES;
                  key_in      = 32'd0;
                  phase_in    = wsfd_pkg::PH_MASK;
               end else begin
                  count_in = 64'd0;
                  phase_in = (len7 == 7'd0) ? wsfd_pkg::PH_SKIP : wsfd_pkg::PH_DATA;
               end
            end
         end
         wsfd_pkg::PH_EXT: begin
            length_in   = {length_ff[55:0], rx_byte};
            ext_left_in = ext_left_ff - 4'd1;
            if (ext_left_in == 4'd0) begin
               if (masked_ff) begin
                  key_left_in = wsfd_pkg::MASK_KEY_BYTES;
                  key_in      = 32'd0;
                  phase_in    = wsfd_pkg::PH_MASK;
               end else begin
                  count_in  = 64'd0;
                  after_len = (length_in == 64'd0) ? wsfd_pkg::PH_SKIP
                                                   : wsfd_pkg::PH_DATA;
                  phase_in  = after_len;
               end
            end
         end
         wsfd_pkg::PH_MASK: begin
            key_in      = {key_ff[23:0], rx_byte};
            key_left_in = key_left_ff - 3'd1;
            if (key_left_in == 3'd0) begin
               count_in = 64'd0;
               phase_in = (length_ff == 64'd0) ? wsfd_pkg::PH_SKIP : wsfd_pkg::PH_DATA;
            end
         end
         wsfd_pkg::PH_DATA: begin
            result.emit         = 1'b1;
            result.payload_byte = rx_byte ^ key_byte;
            count_in            = count_inc;
            if (count_inc == length_ff) begin
               result.payload_last = 1'b1;
               phase_in            = wsfd_pkg::PH_SKIP;
            end
         end
         default: begin
         end
      endcase

      if (chunk_end) begin
         if (result.emit) begin
            if (!result.payload_last) begin
               result.payload_last = 1'b1;
               result.truncated    = 1'b1;
            end
         end else if (phase_in == wsfd_pkg::PH_EXT ||
                      ((phase_in == wsfd_pkg::PH_MASK || phase_in == wsfd_pkg::PH_DATA)
                       && length_in != 64'd0)) begin
            result.emit         = 1'b1;
            result.payload_byte = 8'h00;
            result.payload_last = 1'b1;
            result.truncated    = 1'b1;
         end
         phase_in    = wsfd_pkg::PH_HDR0;
         ext_left_in = 4'd0;
         key_left_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsfd_pkg::PH_HDR0;
         ext_left_ff <= 4'd0;
         length_ff   <= 64'd0;
         count_ff    <= 64'd0;
         key_ff      <= 32'd0;
         key_left_ff <= 3'd0;
         masked_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         key_ff      <= key_in;
         key_left_ff <= key_left_in;
         masked_ff   <= masked_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/wsfd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_payload_last,
   input wire logic       rsp_truncated
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_payload_last)
      else $error("truncated word not marked last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_payload_last) && $stable(rsp_truncated))
      else $error("stalled result changed");

   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty result register");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_payload_last (rsp_payload_last),
   .rsp_truncated    (rsp_truncated)
);
`default_nettype wire

// ----- tb/sv/frame_payload_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_payload_checker
// Watches both channels of the frame deframer. Each accepted input word is
// run through a cycle-free parser model that tracks header, extended length,
// mask key and payload position. The payload words it predicts are queued and
// compared field by field against every accepted result word.
// ----------------------------------------------------------------------------
module frame_payload_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_chunk_end,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_payload_byte,
   input  wire logic       rsp_payload_last,
   input  wire logic       rsp_truncated,
   output int              fail_count,
   output int              pending,
   output int              words_checked,
   output int              truncations_seen
);

   wsfd_pkg::phase_type       frm_phase    = wsfd_pkg::PH_HDR0;
   logic [3:0]                ext_left     = '0;
   logic [63:0]               frame_len    = '0;
   logic [63:0]               data_count   = '0;
   logic [31:0]               key_word     = '0;
   logic [2:0]                key_left     = '0;
   logic                      frame_masked = 1'b0;
   wsfd_pkg::step_result_type payload_due [$];

   initial begin
      fail_count       = 0;
      pending          = 0;
      words_checked    = 0;
      truncations_seen = 0;
   end

   function automatic void start_data();
      data_count = '0;
      frm_phase  = (frame_len == 64'd0) ? wsfd_pkg::PH_SKIP : wsfd_pkg::PH_DATA;
   endfunction

   function automatic void after_length();
      if (frame_masked) begin
         key_left  = wsfd_pkg::MASK_KEY_BYTES;
         key_word  = '0;
         frm_phase = wsfd_pkg::PH_MASK;
      end else begin
         start_data();
      end
   endfunction

   function automatic wsfd_pkg::step_result_type parse_word(input logic [7:0] b,
                                                            input logic chunk_done);
      wsfd_pkg::step_result_type r;
      logic [7:0]                len7;
      logic [7:0]                key_byte;
      r = '0;
      case (frm_phase)
         wsfd_pkg::PH_HDR0: begin
            if ((b & wsfd_pkg::FIN_BIT) != 8'h00 &&
                (b & wsfd_pkg::OPCODE_FIELD) == wsfd_pkg::OPCODE_TEXT)
               frm_phase = wsfd_pkg::PH_HDR1;
            else
               frm_phase = wsfd_pkg::PH_SKIP;
         end
         wsfd_pkg::PH_HDR1: begin
            len7         = b & wsfd_pkg::LEN7_FIELD;
            frame_masked = (b & wsfd_pkg::MASK_BIT) != 8'h00;
            frame_len    = '0;
            if (len7[6:0] == wsfd_pkg::LEN_EXT16) begin
               ext_left  = wsfd_pkg::EXT16_BYTES;
               frm_phase = wsfd_pkg::PH_EXT;
            end else if (len7[6:0] == wsfd_pkg::LEN_EXT64) begin
               ext_left  = wsfd_pkg::EXT64_BYTES;
               frm_phase = wsfd_pkg::PH_EXT;
            end else begin
               frame_len = {56'd0, len7};
               after_length();
            end
         end
         wsfd_pkg::PH_EXT: begin
            frame_len = {frame_len[55:0], b};
            ext_left  = ext_left - 4'd1;
            if (ext_left == 4'd0)
               after_length();
         end
         wsfd_pkg::PH_MASK: begin
            key_word = {key_word[23:0], b};
            key_left = key_left - 3'd1;
            if (key_left == 3'd0)
               start_data();
         end
         wsfd_pkg::PH_DATA: begin
            key_byte       = frame_masked ? 8'(key_word >> {~data_count[1:0], 3'b000})
                                          : 8'h00;
            r.emit         = 1'b1;
            r.payload_byte = b ^ key_byte;
            data_count     = data_count + 64'd1;
            if (data_count == frame_len) begin
               r.payload_last = 1'b1;
               frm_phase      = wsfd_pkg::PH_SKIP;
            end
         end
         default: begin
         end
      endcase

      if (chunk_done) begin
         if (r.emit) begin
            if (!r.payload_last) begin
               r.payload_last = 1'b1;
               r.truncated    = 1'b1;
            end
         end else if (frm_phase == wsfd_pkg::PH_EXT ||
                      ((frm_phase == wsfd_pkg::PH_MASK || frm_phase == wsfd_pkg::PH_DATA)
                       && frame_len != 64'd0)) begin
            r.emit         = 1'b1;
            r.payload_byte = 8'h00;
            r.payload_last = 1'b1;
            r.truncated    = 1'b1;
         end
         frm_phase = wsfd_pkg::PH_HDR0;
         ext_left  = '0;
         key_left  = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      wsfd_pkg::step_result_type due;
      wsfd_pkg::step_result_type got;
      if (reset) begin
         frm_phase    = wsfd_pkg::PH_HDR0;
         ext_left     = '0;
         frame_len    = '0;
         data_count   = '0;
         key_word     = '0;
         key_left     = '0;
         frame_masked = 1'b0;
         payload_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (payload_due.size() == 0) begin
               $error("unexpected result word: payload_byte %02h, payload_last %0b, truncated %0b",
                      rsp_payload_byte, rsp_payload_last, rsp_truncated);
               fail_count++;
            end else begin
               due = payload_due.pop_front();
               words_checked++;
               if (due.truncated)
                  truncations_seen++;
               if (rsp_payload_byte !== due.payload_byte) begin
                  $error("payload_byte: expected %02h, actual %02h",
                         due.payload_byte, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_payload_last !== due.payload_last) begin
                  $error("payload_last: expected %0b, actual %0b",
                         due.payload_last, rsp_payload_last);
                  fail_count++;
               end
               if (rsp_truncated !== due.truncated) begin
                  $error("truncated: expected %0b, actual %0b", due.truncated, rsp_truncated);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            got = parse_word(req_rx_byte, req_chunk_end);
            if (got.emit)
               payload_due.push_back(got);
         end
      end
      pending <= payload_due.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received frame chunks into the deframer: a short directed set of
// headers, rejects and truncations, then random text frames with short,
// 16-bit and 64-bit lengths, masked or not, complete, padded or cut short,
// mixed with noise chunks. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STREAM_WORDS = 1250;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_word_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte   = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_last;
   logic       rsp_truncated;

   int fail_count;
   int pending;
   int words_checked;
   int truncations_seen;
   int cycle_count = 0;
   int words_sent  = 0;
   int chunk_count = 0;

   rx_word_type rx_stream [$];

   always #2 clock = ~clock;

   websocket_frame_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_chunk_end    (req_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .rsp_truncated    (rsp_truncated)
   );

   frame_payload_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_chunk_end    (req_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .rsp_truncated    (rsp_truncated),
      .fail_count       (fail_count),
      .pending          (pending),
      .words_checked    (words_checked),
      .truncations_seen (truncations_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic void queue_word(input logic [7:0] b, input logic last);
      rx_word_type w;
      w.data = b;
      w.last = last;
      rx_stream.push_back(w);
      if (last)
         chunk_count++;
   endfunction

   function automatic void add_random_chunk();
      logic [7:0]  body [$];
      logic [7:0]  rnd;
      logic [63:0] declared;
      logic        masked;
      int          sel;
      int          len_mode;
      int          present;
      int          cut;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         // noise: random first byte, short random tail
         body.push_back(8'($urandom));
         repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
      end else begin
         masked   = 1'($urandom_range(0, 1));
         len_mode = $urandom_range(0, 9);
         rnd      = 8'($urandom);
         body.push_back(wsfd_pkg::FIN_BIT | (rnd & 8'h70) | wsfd_pkg::OPCODE_TEXT);
         if (len_mode <= 5) begin
            declared = 64'($urandom_range(0, 12));
            body.push_back({masked, declared[6:0]});
         end else if (len_mode == 6) begin
            declared = 64'($urandom_range(13, 125));
            body.push_back({masked, declared[6:0]});
         end else if (len_mode <= 8) begin
            declared = (len_mode == 7) ? 64'($urandom_range(0, 40))
                                       : 64'($urandom_range(0, 65535));
            body.push_back({masked, wsfd_pkg::LEN_EXT16});
            body.push_back(declared[15:8]);
            body.push_back(declared[7:0]);
         end else begin
            declared = $urandom_range(0, 1) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
            body.push_back({masked, wsfd_pkg::LEN_EXT64});
            for (int i = 7; i >= 0; i--)
               body.push_back(declared[8*i +: 8]);
         end
         if (masked)
            repeat (4) body.push_back(8'($urandom));
         present = (declared > 64'd200) ? $urandom_range(0, 24) : int'(declared);
         repeat (present) body.push_back(8'($urandom));
         sel = $urandom_range(0, 99);
         if (declared <= 64'd200 && sel >= 60) begin
            if (sel < 75) begin
               repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
            end else begin
               cut = $urandom_range(1, body.size());
               while (body.size() > cut)
                  void'(body.pop_back());
            end
         end
      end
      foreach (body[i])
         queue_word(body[i], i == body.size() - 1);
   endfunction

   // receiver: random ready pattern, one long hold-off while the sender keeps going
   initial begin : receiver
      int gap;
      int run;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && words_sent > 400) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : sender
      rx_word_type w;
      int          gap;
      int          pause_at;
      bit          burst;
      burst = 1'b0;

      // single-byte chunk
      queue_word(8'h81, 1'b1);
      // non-final frame, then wrong opcode
      queue_word(8'h01, 1'b0); queue_word(8'h81, 1'b1);
      queue_word(8'h82, 1'b0); queue_word(8'h05, 1'b1);
      // one unmasked byte, all ones
      queue_word(8'h81, 1'b0); queue_word(8'h01, 1'b0); queue_word(8'hFF, 1'b1);
      // empty payload with a trailing byte
      queue_word(8'h81, 1'b0); queue_word(8'h00, 1'b0); queue_word(8'h55, 1'b1);
      // chunk ends right after the header of a nonzero length
      queue_word(8'h81, 1'b0); queue_word(8'h05, 1'b1);
      // chunk ends inside a 16-bit length
      queue_word(8'h81, 1'b0); queue_word(8'h7E, 1'b0); queue_word(8'h00, 1'b1);
      // masked payload cut short on its second byte
      queue_word(8'hF1, 1'b0); queue_word(8'h85, 1'b0);
      queue_word(8'hA5, 1'b0); queue_word(8'h5A, 1'b0);
      queue_word(8'hFF, 1'b0); queue_word(8'h00, 1'b0);
      queue_word(8'h00, 1'b0); queue_word(8'hFF, 1'b1);

      while (rx_stream.size() < STREAM_WORDS)
         add_random_chunk();
      pause_at = rx_stream.size() / 2;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);

      foreach (rx_stream[i]) begin
         if (i % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : pick_gap();
         if (i == pause_at) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         w = rx_stream[i];
         req_valid     <= 1'b1;
         req_rx_byte   <= w.data;
         req_chunk_end <= w.last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         words_sent++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words in %0d chunks (headers, rejects, masks, 16/64-bit lengths).",
               words_sent, chunk_count);
      $display("Checked %0d payload words, %0d of them flagged truncated.",
               words_checked, truncations_seen);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
